// ===== rtl/csa_pkg.sv =====
// Shared types, codes and constants for the clock set source arbiter.
package csa_pkg;

  // Source codes; a higher code ranks better.
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_LIMIT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd2024;
  localparam logic [11:0] MAX_YEAR_RESET = 12'd2099;

  // Arithmetic constants.
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [16:0] SEC_UNIT     = 17'd1;
  localparam logic [16:0] DAYS_PER_YR  = 17'd365;
  // ceil(2^15 / 25): exact quotient by 25 for dividends below 2048.
  localparam logic [16:0] RECIP_25     = 17'd1311;
  // One 400-year era (146097) for the shifted year, the epoch shift (719468)
  // and the one from day-of-month counting from 1.
  localparam logic [23:0] DAY_BIAS     = 24'd865566;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SOURCE = 2'd1,
    ST_OUTRANKED = 2'd2,
    ST_BAD_DATE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_Q100,
    PH_DAYS,
    PH_SCALE,
    PH_HOUR,
    PH_MIN,
    PH_SEC,
    PH_CHECK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0]  source;
    logic [11:0] year;
    logic [3:0]  month;
    logic [5:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] epoch_seconds;
    logic [1:0]  current_source;
  } rsp_t;

  // One command to the shared multiply-accumulate unit: acc = a * b + c.
  typedef struct packed {
    logic               en;
    logic signed [23:0] a;
    logic [16:0]        b;
    logic signed [39:0] c;
  } mac_op_t;

  // Days from March 1 to the first of the month, month index counted from March.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] days;
    unique case (mp)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/csa_req_if.sv =====
// Request channel: valid/ready handshake carrying one time-set request.
interface csa_req_if;
  logic          valid;
  logic          ready;
  csa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/csa_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one arbitration result.
interface csa_rsp_if;
  logic          valid;
  logic          ready;
  csa_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/csa_mac.sv =====
// Shared multiply-accumulate unit with a registered accumulator.
module csa_mac (
  input  logic                   clk,
  input  csa_pkg::mac_op_t       op,
  output logic signed [39:0]     acc
);

  logic signed [41:0] prod;

  assign prod = op.a * $signed({1'b0, op.b});

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= prod[39:0] + op.c;
    end
  end

endmodule

// ===== rtl/csa_ctrl.sv =====
// Request sequencer: source arbitration, range checks and epoch conversion steps.
module csa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic [11:0]        min_year,
  input  logic [11:0]        max_year,
  input  logic signed [39:0] acc,
  output csa_pkg::mac_op_t   op,
  csa_req_if.sink            req,
  csa_rsp_if.source          rsp
);

  csa_pkg::phase_t  state;
  csa_pkg::phase_t  state_next;
  csa_pkg::status_t pre_status;
  csa_pkg::status_t status_r;
  logic [31:0]      epoch_r;
  logic [1:0]       clock_source;
  logic [1:0]       src_r;
  logic [12:0]      ys_r;
  logic [3:0]       mp_r;
  logic [5:0]       day_r;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [5:0]       second_r;
  logic [12:0]      ys_in;
  logic [3:0]       mp_in;
  logic [10:0]      q4;
  logic [10:0]      q100;
  logic [8:0]       q400;
  logic [23:0]      day_sum;
  logic             in_range;
  logic             take;

  // Year shifted to start in March and moved up one era to stay nonnegative.
  assign ys_in = 13'(req.payload.year) + 13'd400
               - ((req.payload.month <= 4'd2) ? 13'd1 : 13'd0);
  assign mp_in = (req.payload.month > 4'd2) ? req.payload.month - 4'd3
                                            : req.payload.month + 4'd9;

  assign q4   = ys_r[12:2];
  assign q100 = acc[25:15];
  assign q400 = q100[10:2];
  assign day_sum = 24'(q4) - 24'(q100) + 24'(q400) + 24'(csa_pkg::month_start(mp_r))
                 + 24'(day_r) - csa_pkg::DAY_BIAS;

  assign in_range = (acc[39:32] == 8'd0) && (acc[31:0] != 32'd0);
  assign take     = req.valid && req.ready;

  always_comb begin
    priority if (req.payload.source == csa_pkg::SRC_NONE ||
                 req.payload.source > csa_pkg::SRC_LIMIT) begin
      pre_status = csa_pkg::ST_NO_SOURCE;
    end else if (req.payload.source < clock_source) begin
      pre_status = csa_pkg::ST_OUTRANKED;
    end else if (req.payload.year < min_year || req.payload.year > max_year ||
                 req.payload.month < 4'd1 || req.payload.month > 4'd12 ||
                 req.payload.day > 6'd32 || req.payload.hour > 5'd23 ||
                 req.payload.minute > 6'd59 || req.payload.second > 6'd60) begin
      pre_status = csa_pkg::ST_BAD_DATE;
    end else begin
      pre_status = csa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csa_pkg::PH_IDLE;
      clock_source <= csa_pkg::SRC_NONE;
    end else begin
      state <= state_next;
      if (state == csa_pkg::PH_CHECK && in_range) begin
        clock_source <= src_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      src_r    <= req.payload.source;
      ys_r     <= ys_in;
      mp_r     <= mp_in;
      day_r    <= req.payload.day;
      hour_r   <= req.payload.hour;
      minute_r <= req.payload.minute;
      second_r <= req.payload.second;
      status_r <= pre_status;
      epoch_r  <= 32'd0;
    end else if (state == csa_pkg::PH_CHECK) begin
      status_r <= in_range ? csa_pkg::ST_OK : csa_pkg::ST_BAD_DATE;
      epoch_r  <= in_range ? acc[31:0] : 32'd0;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    op         = '0;
    unique case (state)
      csa_pkg::PH_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (pre_status == csa_pkg::ST_OK) ? csa_pkg::PH_Q100
                                                      : csa_pkg::PH_DONE;
        end
      end
      csa_pkg::PH_Q100: begin
        op.en      = 1'b1;
        op.a       = 24'(q4);
        op.b       = csa_pkg::RECIP_25;
        state_next = csa_pkg::PH_DAYS;
      end
      csa_pkg::PH_DAYS: begin
        op.en      = 1'b1;
        op.a       = 24'(ys_r);
        op.b       = csa_pkg::DAYS_PER_YR;
        op.c       = {{16{day_sum[23]}}, day_sum};
        state_next = csa_pkg::PH_SCALE;
      end
      csa_pkg::PH_SCALE: begin
        op.en      = 1'b1;
        op.a       = acc[23:0];
        op.b       = csa_pkg::SEC_PER_DAY;
        state_next = csa_pkg::PH_HOUR;
      end
      csa_pkg::PH_HOUR: begin
        op.en      = 1'b1;
        op.a       = 24'(hour_r);
        op.b       = csa_pkg::SEC_PER_HOUR;
        op.c       = acc;
        state_next = csa_pkg::PH_MIN;
      end
      csa_pkg::PH_MIN: begin
        op.en      = 1'b1;
        op.a       = 24'(minute_r);
        op.b       = csa_pkg::SEC_PER_MIN;
        op.c       = acc;
        state_next = csa_pkg::PH_SEC;
      end
      csa_pkg::PH_SEC: begin
        op.en      = 1'b1;
        op.a       = 24'(second_r);
        op.b       = csa_pkg::SEC_UNIT;
        op.c       = acc;
        state_next = csa_pkg::PH_CHECK;
      end
      csa_pkg::PH_CHECK: begin
        state_next = csa_pkg::PH_DONE;
      end
      csa_pkg::PH_DONE: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = csa_pkg::PH_IDLE;
        end
      end
      default: begin
        state_next = csa_pkg::PH_IDLE;
      end
    endcase
  end

  assign rsp.payload.status         = status_r;
  assign rsp.payload.epoch_seconds  = epoch_r;
  assign rsp.payload.current_source = clock_source;

  a_ok_has_epoch: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && status_r == csa_pkg::ST_OK |-> epoch_r != 32'd0)
    else $error("accepted result carries zero epoch");

  a_reject_zero_epoch: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && status_r != csa_pkg::ST_OK |-> epoch_r == 32'd0)
    else $error("rejected result carries nonzero epoch");

  a_source_moves_on_ok: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && clock_source != $past(clock_source)
      |-> state == csa_pkg::PH_DONE && status_r == csa_pkg::ST_OK)
    else $error("clock source changed without an accepted request");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !req.ready)
    else $error("new beat taken while a request is in flight");

endmodule

// ===== rtl/clock_set_source_arbiter_top.sv =====
// A result beat is valid in DONE after the states Q100, DAYS, SCALE, HOUR, MIN, SEC
// and CHECK when the date is converted, and in the cycle after the take when the request
// is refused by source or range. One request is in flight at a time; the shared 24x17
// multiply-accumulate unit walks the conversion in six steps and the block holds
// ready low until the result beat is taken. Synchronous reset sets the clock source
// to none and the year window to 2024..2099.
module clock_set_source_arbiter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  csa_req_if.sink     req,
  csa_rsp_if.source   rsp
);

  // Year window registers; the user writes them only while the block is idle, which the block does not enforce.
  logic [11:0] min_year;
  logic [11:0] max_year;

  csa_pkg::mac_op_t   op;
  logic signed [39:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= csa_pkg::MIN_YEAR_RESET;
      max_year <= csa_pkg::MAX_YEAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csa_pkg::CFG_MIN_YEAR: min_year <= cfg_data;
        csa_pkg::CFG_MAX_YEAR: max_year <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: checks source rank and ranges as the beat is taken, then drives
  // the shared unit through the days-from-civil steps:
  //   year/100 by reciprocal, days = 365*year + leap terms + day of year,
  //   scale to seconds, then add hour, minute and second.
  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .min_year (min_year),
    .max_year (max_year),
    .acc      (acc),
    .op       (op),
    .req      (req),
    .rsp      (rsp)
  );

  // Shared multiply-accumulate unit; the accumulator holds every partial result.
  csa_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

endmodule
